[design/scs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpentine coverage sequencer package
// Shared codes, field widths, register reset values and interface structs.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int unsigned DistWidth  = 16;
   localparam int unsigned SpeedWidth = 8;
   localparam int unsigned RowWidth   = 8;
   localparam int unsigned AngleWidth = 8;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 16;

   localparam logic signed [AngleWidth-1:0] TurnRight = 8'sd90;
   localparam logic signed [AngleWidth-1:0] TurnLeft  = -8'sd90;

   // Command codes carried in req_tuser.
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   // Action codes carried in rsp_tuser.
   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_MOVE  = 3'd1;
   localparam logic [2:0] ACT_TURN  = 3'd2;
   localparam logic [2:0] ACT_STOP  = 3'd3;
   localparam logic [2:0] ACT_ABORT = 3'd4;

   // Phase codes as seen on the result channel.
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_RUN   = 3'd1;
   localparam logic [2:0] PH_TOUT  = 3'd2;
   localparam logic [2:0] PH_SHIFT = 3'd3;
   localparam logic [2:0] PH_TBACK = 3'd4;
   localparam logic [2:0] PH_DONE  = 3'd5;
   localparam logic [2:0] PH_ABORT = 3'd6;
   localparam logic [2:0] PH_ERROR = 3'd7;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CSR_LINE_COUNT    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_LINE_LENGTH   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_LINE_SPACING  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_FORWARD_SPEED = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_TURN_SPEED    = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_SHIFT_SPEED   = 3'd5;

   // Register reset values.
   localparam logic [RowWidth-1:0]   RST_LINE_COUNT    = 8'd11;
   localparam logic [DistWidth-1:0]  RST_LINE_LENGTH   = 16'd1000;
   localparam logic [DistWidth-1:0]  RST_LINE_SPACING  = 16'd100;
   localparam logic [SpeedWidth-1:0] RST_FORWARD_SPEED = 8'd120;
   localparam logic [SpeedWidth-1:0] RST_TURN_SPEED    = 8'd60;
   localparam logic [SpeedWidth-1:0] RST_SHIFT_SPEED   = 8'd100;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_RUN   = 8'b0000_0010,
      ST_TOUT  = 8'b0000_0100,
      ST_SHIFT = 8'b0000_1000,
      ST_TBACK = 8'b0001_0000,
      ST_DONE  = 8'b0010_0000,
      ST_ABORT = 8'b0100_0000,
      ST_ERROR = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [RowWidth-1:0]   line_count;
      logic [DistWidth-1:0]  line_length;
      logic [DistWidth-1:0]  line_spacing;
      logic [SpeedWidth-1:0] forward_speed;
      logic [SpeedWidth-1:0] turn_speed;
      logic [SpeedWidth-1:0] shift_speed;
   } cfg_type;

   typedef struct packed {
      logic [1:0] command;
      logic       start_ready;
      logic       prim_error;
      logic       prim_busy;
      logic       prim_done;
   } req_type;

   typedef struct packed {
      phase_type           phase;
      logic                running;
      logic                pending;
      logic [RowWidth-1:0] row;
      logic                turn_left;
   } state_type;

   typedef struct packed {
      logic [2:0]                   action;
      logic [DistWidth-1:0]         distance_mm;
      logic signed [AngleWidth-1:0] angle_deg;
      logic [SpeedWidth-1:0]        speed;
      logic                         clear_done;
      logic [2:0]                   phase;
      logic [RowWidth-1:0]          current_row;
      logic                         active;
   } rsp_type;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      case (ph)
         ST_IDLE:  code = PH_IDLE;
         ST_RUN:   code = PH_RUN;
         ST_TOUT:  code = PH_TOUT;
         ST_SHIFT: code = PH_SHIFT;
         ST_TBACK: code = PH_TBACK;
         ST_DONE:  code = PH_DONE;
         ST_ABORT: code = PH_ABORT;
         ST_ERROR: code = PH_ERROR;
         default:  code = PH_IDLE;
      endcase
      return code;
   endfunction

endpackage

[design/scs_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpentine coverage sequencer configuration registers
// Write-only register file for the run geometry and speeds.
// ----------------------------------------------------------------------------
module scs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [scs_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [scs_pkg::CsrDataWidth-1:0]     csr_wdata,
   output scs_pkg::cfg_type                     cfg
);

   scs_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            scs_pkg::CSR_LINE_COUNT:    cfg_in.line_count    = csr_wdata[7:0];
            scs_pkg::CSR_LINE_LENGTH:   cfg_in.line_length   = csr_wdata;
            scs_pkg::CSR_LINE_SPACING:  cfg_in.line_spacing  = csr_wdata;
            scs_pkg::CSR_FORWARD_SPEED: cfg_in.forward_speed = csr_wdata[7:0];
            scs_pkg::CSR_TURN_SPEED:    cfg_in.turn_speed    = csr_wdata[7:0];
            scs_pkg::CSR_SHIFT_SPEED:   cfg_in.shift_speed   = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_count    <= scs_pkg::RST_LINE_COUNT;
         cfg_ff.line_length   <= scs_pkg::RST_LINE_LENGTH;
         cfg_ff.line_spacing  <= scs_pkg::RST_LINE_SPACING;
         cfg_ff.forward_speed <= scs_pkg::RST_FORWARD_SPEED;
         cfg_ff.turn_speed    <= scs_pkg::RST_TURN_SPEED;
         cfg_ff.shift_speed   <= scs_pkg::RST_SHIFT_SPEED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/scs_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpentine coverage sequencer step logic
// Next-state and motion command decode for one registered input transfer.
// ----------------------------------------------------------------------------
module scs_step (
   input  scs_pkg::cfg_type   cfg,
   input  scs_pkg::state_type cur,
   input  scs_pkg::req_type   item,
   output scs_pkg::state_type nxt,
   output scs_pkg::rsp_type   result
);

   logic [scs_pkg::RowWidth-1:0] row_inc;
   logic                         last_line;

   assign row_inc   = cur.row + 8'd1;
   assign last_line = (row_inc >= cfg.line_count);

   always_comb begin
      nxt                = cur;
      result             = '0;
      case (item.command)
         scs_pkg::CMD_TICK: begin
            if (cur.pending && item.start_ready) begin
               // A pending start launches the first line; the move is now busy.
               nxt.pending        = 1'b0;
               nxt.running        = 1'b1;
               nxt.row            = '0;
               nxt.phase          = scs_pkg::ST_RUN;
               result.action      = scs_pkg::ACT_MOVE;
               result.distance_mm = cfg.line_length;
               result.speed       = cfg.forward_speed;
            end else if (cur.running) begin
               if (item.prim_error) begin
                  nxt.running   = 1'b0;
                  nxt.phase     = scs_pkg::ST_ERROR;
                  result.action = scs_pkg::ACT_STOP;
               end else if (!item.prim_busy && item.prim_done) begin
                  result.clear_done = 1'b1;
                  case (cur.phase)
                     scs_pkg::ST_RUN: begin
                        if (last_line) begin
                           nxt.running   = 1'b0;
                           nxt.phase     = scs_pkg::ST_DONE;
                           result.action = scs_pkg::ACT_STOP;
                        end else begin
                           // Even rows turn right, odd rows turn left.
                           nxt.turn_left    = cur.row[0];
                           nxt.phase        = scs_pkg::ST_TOUT;
                           result.action    = scs_pkg::ACT_TURN;
                           result.angle_deg = cur.row[0] ? scs_pkg::TurnLeft
                                                         : scs_pkg::TurnRight;
                           result.speed     = cfg.turn_speed;
                        end
                     end
                     scs_pkg::ST_TOUT: begin
                        nxt.phase          = scs_pkg::ST_SHIFT;
                        result.action      = scs_pkg::ACT_MOVE;
                        result.distance_mm = cfg.line_spacing;
                        result.speed       = cfg.shift_speed;
                     end
                     scs_pkg::ST_SHIFT: begin
                        nxt.phase        = scs_pkg::ST_TBACK;
                        result.action    = scs_pkg::ACT_TURN;
                        result.angle_deg = cur.turn_left ? scs_pkg::TurnLeft
                                                         : scs_pkg::TurnRight;
                        result.speed     = cfg.turn_speed;
                     end
                     scs_pkg::ST_TBACK: begin
                        nxt.row            = row_inc;
                        nxt.phase          = scs_pkg::ST_RUN;
                        result.action      = scs_pkg::ACT_MOVE;
                        result.distance_mm = cfg.line_length;
                        result.speed       = cfg.forward_speed;
                     end
                     default: ;
                  endcase
               end
            end
         end
         scs_pkg::CMD_START: begin
            if (!cur.running && !cur.pending) begin
               if (!item.start_ready) begin
                  nxt.pending = 1'b1;
               end else begin
                  nxt.running        = 1'b1;
                  nxt.row            = '0;
                  nxt.phase          = scs_pkg::ST_RUN;
                  result.action      = scs_pkg::ACT_MOVE;
                  result.distance_mm = cfg.line_length;
                  result.speed       = cfg.forward_speed;
               end
            end
         end
         scs_pkg::CMD_STOP: begin
            nxt.pending = 1'b0;
            if (cur.phase == scs_pkg::ST_IDLE) begin
               result.action = scs_pkg::ACT_STOP;
            end else begin
               nxt.running   = 1'b0;
               nxt.phase     = scs_pkg::ST_ABORT;
               result.action = scs_pkg::ACT_ABORT;
            end
         end
         default: ;
      endcase
      result.phase       = scs_pkg::phase_code(nxt.phase);
      result.current_row = nxt.row;
      result.active      = nxt.running | nxt.pending;
   end

endmodule

[design/serpentine_coverage_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpentine coverage sequencer core
// Lawn-mower path sequencer: runs lines, turns out, shifts, turns back and
// gives at most one motion command per command or tick transfer.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  req_    | in        | tuser: command; tdata: ready and primitive status
//  rsp_    | out       | tuser: action; tdata: motion arguments and status
//  csr_    | in        | write enable, register index, write data
//
// One transfer is taken per cycle while req_tready is high; each request
// passes through the input register and then the result register, from
// which its result transfer completes once rsp_tready is high.
// The sequencer state is updated in the same cycle the result is registered,
// so the next transfer sees it without a bubble.
// Reset is synchronous and restores the configuration defaults and idle state.
// A stalled result holds the output register; req_tready drops only when both
// the input and result registers are full.
// ----------------------------------------------------------------------------
module serpentine_coverage_sequencer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] start_ready, [1] prim_error, [2] prim_busy, [3] prim_done, [7:4] zero
   input  logic [7:0]                           req_tdata,
   // [1:0] command
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] distance_mm, [23:16] angle_deg, [31:24] speed, [32] clear_done,
   // [35:33] phase, [43:36] current_row, [44] active, [47:45] zero
   output logic [47:0]                          rsp_tdata,
   // [2:0] action
   output logic [2:0]                           rsp_tuser,
   input  logic                                 csr_we,
   input  logic [scs_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [scs_pkg::CsrDataWidth-1:0]     csr_wdata
);

   scs_pkg::cfg_type   cfg;
   scs_pkg::req_type   item_ff, item_in;
   logic               item_valid_ff, item_valid_in;
   scs_pkg::state_type state_ff, state_in, state_nxt;
   scs_pkg::rsp_type   rsp_ff, rsp_in, step_rsp;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;
   logic               advance;
   logic               req_xfer;

   scs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   scs_step u_step (
      .cfg    (cfg),
      .cur    (state_ff),
      .item   (item_ff),
      .nxt    (state_nxt),
      .result (step_rsp)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && out_free;
   assign req_tready = !item_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_xfer) begin
         item_in.command     = req_tuser;
         item_in.start_ready = req_tdata[0];
         item_in.prim_error  = req_tdata[1];
         item_in.prim_busy   = req_tdata[2];
         item_in.prim_done   = req_tdata[3];
         item_valid_in       = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         state_in     = state_nxt;
         rsp_in       = step_rsp;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff      <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         state_ff.phase     <= scs_pkg::ST_IDLE;
         state_ff.running   <= 1'b0;
         state_ff.pending   <= 1'b0;
         state_ff.row       <= '0;
         state_ff.turn_left <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.action;
   assign rsp_tdata  = {3'b000, rsp_ff.active, rsp_ff.current_row, rsp_ff.phase,
                        rsp_ff.clear_done, rsp_ff.speed, rsp_ff.angle_deg,
                        rsp_ff.distance_mm};

`ifndef SYNTHESIS
   // The running and pending flags are exclusive.
   assert property (@(posedge clock) disable iff (reset)
      !(state_ff.running && state_ff.pending))
      else $error("running and pending both set");

   // While running, the phase is one of the four motion phases.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.running |-> (state_ff.phase == scs_pkg::ST_RUN ||
                            state_ff.phase == scs_pkg::ST_TOUT ||
                            state_ff.phase == scs_pkg::ST_SHIFT ||
                            state_ff.phase == scs_pkg::ST_TBACK))
      else $error("running outside a motion phase");

   // A turn command always carries a quarter turn.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.action == scs_pkg::ACT_TURN) |->
         (rsp_ff.angle_deg == scs_pkg::TurnRight ||
          rsp_ff.angle_deg == scs_pkg::TurnLeft))
      else $error("turn command without a quarter-turn angle");

   // The state only changes when a transfer moves into the result register.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a transfer");
`endif

endmodule
